[src/grid_astar_path_search_top_defines.svh]
// Assertion macros for the grid A* search block.
// Used by the top level only.
`ifndef GRID_ASTAR_PATH_SEARCH_TOP_DEFINES_SVH
`define GRID_ASTAR_PATH_SEARCH_TOP_DEFINES_SVH
// assert that a implies b on the next cycle
`define GAS_ASSERT_NEXT(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
// assert that a implies b in the same cycle
`define GAS_ASSERT_NOW(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);
`endif

[src/gas_pkg.sv]
// Package for the grid A* search block: types, codes, neighbor offsets.
// No dependencies.
`default_nettype none
package gas_pkg;
  localparam int GRID_ROWS = 8;
  localparam int GRID_COLS = 8;

  localparam logic [1:0] ST_PATH    = 2'd0;
  localparam logic [1:0] ST_RANGE   = 2'd1;
  localparam logic [1:0] ST_BLOCKED = 2'd2;
  localparam logic [1:0] ST_NOPATH  = 2'd3;
  localparam logic [15:0] SAT16 = 16'hFFFF;

  // row/col offsets of the eight neighbors, in expansion order
  function automatic logic signed [1:0] nbr_dr(input logic [2:0] k);
    case (k)
      3'd0, 3'd6, 3'd7: nbr_dr = -2'sd1;
      3'd1, 3'd5:       nbr_dr = 2'sd0;
      default:          nbr_dr = 2'sd1;
    endcase
  endfunction
  function automatic logic signed [1:0] nbr_dc(input logic [2:0] k);
    case (k)
      3'd0, 3'd1, 3'd2: nbr_dc = -2'sd1;
      3'd3, 3'd7:       nbr_dc = 2'sd0;
      default:          nbr_dc = 2'sd1;
    endcase
  endfunction

  function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add = s[16] ? SAT16 : s[15:0];
  endfunction

  typedef enum logic [7:0] {
    S_IDLE   = 8'b00000001,
    S_CLEAR  = 8'b00000010,
    S_SCAN   = 8'b00000100,
    S_PICK   = 8'b00001000,
    S_NBR    = 8'b00010000,
    S_UPD    = 8'b00100000,
    S_OUT    = 8'b01000000,
    S_WALK   = 8'b10000000
  } state_t;

  // command from the controller to every cell
  typedef struct packed {
    logic       clear;     // start of search: drop flags
    logic       seed;      // initialize start cell
    logic       close;     // close the selected cell
    logic       upd;       // write f into the addressed cell; g/parent go to the RAMs
    logic [5:0] addr;
    logic [15:0] g;
    logic [15:0] f;
    logic [5:0] parent;
  } cell_cmd_t;

  // minimum candidate passed along the chain
  typedef struct packed {
    logic       vld;
    logic [15:0] f;
    logic [5:0] idx;
  } cand_t;
endpackage
`default_nettype wire

[src/gas_if.sv]
// Valid/ready channel interface used on both sides of the block.
// Depends on nothing.
`default_nettype none
interface gas_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [3:0] cell_row;
  logic [3:0] cell_col;
  logic       blocked;
  logic [3:0] goal_row;
  logic [3:0] goal_col;
  modport source (output valid, op, cell_row, cell_col, blocked, goal_row, goal_col,
                  input ready);
  modport sink (input valid, op, cell_row, cell_col, blocked, goal_row, goal_col,
                output ready);
endinterface

interface gas_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] path_row;
  logic [2:0] path_col;
  logic [1:0] status;
  logic       last;
  modport source (output valid, path_row, path_col, status, last, input ready);
  modport sink (input valid, path_row, path_col, status, last, output ready);
endinterface
`default_nettype wire

[src/gas_ram.sv]
// Generic single-port write, one-port registered-read RAM.
// No dependencies.
`default_nettype none
module gas_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[src/gas_cell.sv]
// One grid cell of the search chain: open/closed/reached flags and f value.
// Compares its own candidate against the one handed in from its neighbor.
// Depends on gas_pkg.
`default_nettype none
module gas_cell import gas_pkg::*; #(
  parameter logic [5:0] IDX = 6'd0
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cell_cmd_t cmd,
  input  wire cand_t     cand_in,
  output cand_t          cand_out,
  output logic           closed,
  output logic           reached,
  output logic [15:0]    f_val
);
  logic open_r, closed_r, reached_r;
  logic [15:0] f_r;
  cand_t cand_r;
  logic mine;

  assign mine = cmd.addr == IDX;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
      closed_r <= 1'b0;
      reached_r <= 1'b0;
      cand_r.vld <= 1'b0;
    end else begin
      if (cmd.clear) begin
        open_r <= 1'b0;
        closed_r <= 1'b0;
        reached_r <= 1'b0;
      end else if ((cmd.seed || cmd.upd) && mine) begin
        open_r <= 1'b1;
        reached_r <= 1'b1;
      end else if (cmd.close && mine) begin
        open_r <= 1'b0;
        closed_r <= 1'b1;
      end
      // lower index wins ties: incoming comes from lower cells
      if (open_r && (!cand_in.vld || f_r < cand_in.f)) begin
        cand_r.vld <= 1'b1;
        cand_r.f <= f_r;
        cand_r.idx <= IDX;
      end else begin
        cand_r <= cand_in;
      end
    end
    if ((cmd.seed || cmd.upd) && mine && !cmd.clear) f_r <= cmd.f;
  end

  assign cand_out = cand_r;
  assign closed = closed_r;
  assign reached = reached_r;
  assign f_val = f_r;
endmodule
`default_nettype wire

[src/grid_astar_path_search_top.sv]
// Top level of the grid A* search: controller, cell chain, g and parent RAMs.
// Depends on gas_pkg, gas_if, gas_ram, gas_cell and the defines header.
//
// channel | dir | handshake   | payload
// in      | in  | valid/ready | op, cell_row, cell_col, blocked, goal_row, goal_col
// out     | out | valid/ready | path_row, path_col, status, last
//
// A map write is taken in idle. A search seeds the start cell, then per
// expansion scans while the minimum ripples down the cell chain, then picks,
// reads the g RAM and tries each of the eight neighbors in turn.
// Path output reads the parent RAM for each path cell, and stalls hold it.
// Reset is synchronous; a stalled output holds the block. Input is taken only in idle.
`default_nettype none
`include "grid_astar_path_search_top_defines.svh"
module grid_astar_path_search_top import gas_pkg::*; #(
  parameter int FRAC_BITS = 8
) (
  input  wire logic clk,
  input  wire logic rst_n,
  gas_in_if.sink    in_ch,
  gas_out_if.source out_ch
);
  localparam int CELLS = GRID_ROWS * GRID_COLS;

  // rounded Euclidean distance for |dr|,|dc| <= 7, by bitwise sqrt
  function automatic logic [15:0] euclid(input logic [3:0] ar, input logic [3:0] ac);
    logic [47:0] x, r, t;
    x = ({44'd0, ar} * {44'd0, ar} + {44'd0, ac} * {44'd0, ac}) << (2 * FRAC_BITS);
    r = '0;
    for (int b = 16; b >= 0; b--) begin
      t = r | (48'd1 << b);
      if (t * t <= x) r = t;
    end
    if (x - r * r > r) r = r + 48'd1;
    euclid = (r > 48'hFFFF) ? SAT16 : r[15:0];
  endfunction

  logic [15:0] dist_tab [64];
  always_comb begin
    for (int i = 0; i < 64; i++) dist_tab[i] = euclid({1'b0, 3'(i / 8)}, {1'b0, 3'(i % 8)});
  end

  state_t st_r;
  logic [5:0] s_r, g_r, best_r, cur_r;
  logic [2:0] gr_r, gc_r;
  logic [2:0] k_r;
  logic [7:0] cnt_r;
  logic [CELLS-1:0] map_r;
  logic [15:0] gbest_r;
  logic ovld_r, olast_r;
  logic [2:0] orow_r, ocol_r;
  logic [1:0] ost_r;

  cell_cmd_t cmd;
  cand_t chain [CELLS+1];
  logic [CELLS-1:0] closed_v, reached_v;
  logic [15:0] f_v [CELLS];

  assign chain[0] = '{vld: 1'b0, f: 16'd0, idx: 6'd0};
  for (genvar i = 0; i < CELLS; i++) begin : g_cells
    gas_cell #(.IDX(6'(i))) u_cell (
      .clk, .rst_n, .cmd, .cand_in(chain[i]), .cand_out(chain[i+1]),
      .closed(closed_v[i]), .reached(reached_v[i]), .f_val(f_v[i])
    );
  end

  // g RAM and parent RAM
  logic g_we, p_we;
  logic [5:0] g_waddr, g_raddr, p_raddr;
  logic [15:0] g_wdata, g_rdata;
  logic [5:0] p_rdata;
  gas_ram #(.WIDTH(16), .DEPTH(64)) u_gram (
    .clk, .we(g_we), .waddr(g_waddr), .wdata(g_wdata), .raddr(g_raddr), .rdata(g_rdata)
  );
  gas_ram #(.WIDTH(6), .DEPTH(64)) u_pram (
    .clk, .we(p_we), .waddr(g_waddr), .wdata(cmd.parent), .raddr(p_raddr), .rdata(p_rdata)
  );

  // neighbor of best_r for offset k_r
  logic signed [1:0] dr_k, dc_k;
  logic [3:0] br, bc, nr, nc;
  logic in_grid;
  logic [5:0] ni;
  logic [3:0] hr, hc;
  logic [15:0] gnew, fnew;
  logic [2:0] ad;
  always_comb begin
    dr_k = nbr_dr(k_r);
    dc_k = nbr_dc(k_r);
    br = {1'b0, best_r[5:3]};
    bc = {1'b0, best_r[2:0]};
    nr = br + {{2{dr_k[1]}}, dr_k};
    nc = bc + {{2{dc_k[1]}}, dc_k};
    in_grid = !nr[3] && !nc[3] && (nr < 4'(GRID_ROWS)) && (nc < 4'(GRID_COLS));
    ni = {nr[2:0], nc[2:0]};
    hr = (nr >= {1'b0, gr_r}) ? nr - {1'b0, gr_r} : {1'b0, gr_r} - nr;
    hc = (nc >= {1'b0, gc_r}) ? nc - {1'b0, gc_r} : {1'b0, gc_r} - nc;
    ad = {2'b0, 1'b1} + {2'b0, (dr_k != 2'sd0) && (dc_k != 2'sd0)};
    gnew = sat_add(gbest_r, (ad == 3'd2) ? dist_tab[9] : dist_tab[1]);
    fnew = sat_add(gnew, dist_tab[{hr[2:0], hc[2:0]}]);
  end

  logic in_fire, out_fire;
  logic srow_ok, sgoal_ok;
  logic [5:0] s_in, g_in;
  assign in_fire = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;
  assign in_ch.ready = (st_r == S_IDLE) && !ovld_r;
  assign s_in = {in_ch.cell_row[2:0], in_ch.cell_col[2:0]};
  assign g_in = {in_ch.goal_row[2:0], in_ch.goal_col[2:0]};
  assign srow_ok = in_ch.cell_row < 4'(GRID_ROWS) && in_ch.cell_col < 4'(GRID_COLS);
  assign sgoal_ok = in_ch.goal_row < 4'(GRID_ROWS) && in_ch.goal_col < 4'(GRID_COLS);

  logic upd_ok;
  assign upd_ok = in_grid && !map_r[ni] && !closed_v[ni] && (!reached_v[ni] || f_v[ni] > fnew);

  logic [15:0] h0;
  assign h0 = dist_tab[{(s_r[5:3] >= gr_r) ? s_r[5:3] - gr_r : gr_r - s_r[5:3],
                        (s_r[2:0] >= gc_r) ? s_r[2:0] - gc_r : gc_r - s_r[2:0]}];

  always_comb begin
    cmd = '0;
    g_we = 1'b0;
    p_we = 1'b0;
    g_waddr = 6'd0;
    g_raddr = best_r;
    p_raddr = cur_r;
    case (st_r)
      S_IDLE: ;
      S_CLEAR: begin
        cmd.seed = 1'b1;
        cmd.addr = s_r;
        cmd.f = h0;
        cmd.parent = s_r;
        g_we = 1'b1;
        p_we = 1'b1;
        g_waddr = s_r;
      end
      S_SCAN: ;
      S_PICK: ;
      S_NBR: ;
      S_UPD: if (upd_ok) begin
        cmd.upd = 1'b1;
        cmd.addr = ni;
        cmd.f = fnew;
        cmd.g = gnew;
        cmd.parent = best_r;
        g_we = 1'b1;
        p_we = 1'b1;
        g_waddr = ni;
      end
      S_OUT: ;
      S_WALK: ;
      default: ;
    endcase
    g_wdata = cmd.g;
    if (st_r == S_IDLE && in_fire && in_ch.op) cmd.clear = 1'b1;
    if (st_r == S_PICK && chain[CELLS].vld && chain[CELLS].idx != g_r) begin
      cmd.close = 1'b1;
      cmd.addr = chain[CELLS].idx;
      g_raddr = chain[CELLS].idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ovld_r <= 1'b0;
    end else begin
      // in walk the next path item is loaded on the same edge
      if (out_fire && st_r != S_WALK) ovld_r <= 1'b0;
      case (st_r)
        S_IDLE: if (in_fire) begin
          if (!in_ch.op) begin
            if (srow_ok) map_r[s_in] <= in_ch.blocked;
          end else if (!srow_ok || !sgoal_ok) begin
            ovld_r <= 1'b1; ost_r <= ST_RANGE; olast_r <= 1'b1; orow_r <= 3'd0; ocol_r <= 3'd0;
          end else if (map_r[s_in] || map_r[g_in]) begin
            ovld_r <= 1'b1; ost_r <= ST_BLOCKED; olast_r <= 1'b1; orow_r <= 3'd0; ocol_r <= 3'd0;
          end else begin
            s_r <= s_in; g_r <= g_in;
            gr_r <= in_ch.goal_row[2:0]; gc_r <= in_ch.goal_col[2:0];
            st_r <= S_CLEAR;
          end
        end
        S_CLEAR: begin st_r <= S_SCAN; cnt_r <= 8'd0; end
        S_SCAN: begin
          cnt_r <= cnt_r + 8'd1;
          if (cnt_r == 8'(CELLS)) st_r <= S_PICK;
        end
        S_PICK: begin
          if (!chain[CELLS].vld) begin
            ovld_r <= 1'b1; ost_r <= ST_NOPATH; olast_r <= 1'b1; orow_r <= 3'd0; ocol_r <= 3'd0;
            st_r <= S_IDLE;
          end else if (chain[CELLS].idx == g_r) begin
            cur_r <= g_r; st_r <= S_WALK;
          end else begin
            best_r <= chain[CELLS].idx; k_r <= 3'd0; st_r <= S_NBR;
          end
        end
        S_NBR: begin gbest_r <= g_rdata; st_r <= S_UPD; end
        S_UPD: begin
          k_r <= k_r + 3'd1;
          if (k_r == 3'd7) begin st_r <= S_SCAN; cnt_r <= 8'd0; end
        end
        S_WALK: if (!ovld_r || out_fire) begin
          ovld_r <= 1'b1; ost_r <= ST_PATH;
          orow_r <= cur_r[5:3]; ocol_r <= cur_r[2:0];
          olast_r <= cur_r == s_r;
          st_r <= (cur_r == s_r) ? S_IDLE : S_OUT;
        end
        S_OUT: st_r <= S_WALK;
        default: st_r <= S_IDLE;
      endcase
      if (st_r == S_OUT) cur_r <= p_rdata;
    end
  end

  assign out_ch.valid = ovld_r;
  assign out_ch.path_row = orow_r;
  assign out_ch.path_col = ocol_r;
  assign out_ch.status = ost_r;
  assign out_ch.last = olast_r;

  `GAS_ASSERT_NOW(a_err_last, ovld_r && ost_r != ST_PATH, olast_r, "error item without last")
  `GAS_ASSERT_NOW(a_busy_noready, st_r != S_IDLE, !in_ch.ready, "ready while searching")
  `GAS_ASSERT_NEXT(a_hold, ovld_r && !out_ch.ready, ovld_r && $stable(orow_r), "result dropped")
endmodule
`default_nettype wire
